>>> rtl/core/bog_pkg.sv
package bog_pkg;

    // Field widths
    localparam int DIM_BITS    = 16;
    localparam int STRIDE_BITS = 21;
    localparam int NDIM        = 4;
    localparam int OFF_BITS    = 39;
    localparam int PROD_BITS   = DIM_BITS + STRIDE_BITS;

    // Register widths
    localparam int SHAPE_W   = NDIM * DIM_BITS;
    localparam int STRIDES_W = (NDIM - 1) * STRIDE_BITS;
    localparam int CFG_W     = (SHAPE_W > STRIDES_W) ? SHAPE_W : STRIDES_W;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_SHAPE     = 3'd0,
        REG_FIRST_SHAPE    = 3'd1,
        REG_SECOND_SHAPE   = 3'd2,
        REG_DEST_STRIDES   = 3'd3,
        REG_FIRST_STRIDES  = 3'd4,
        REG_SECOND_STRIDES = 3'd5
    } cfg_reg_t;

    // Every extent field reset to one
    localparam logic [SHAPE_W-1:0] SHAPE_RESET = {NDIM{DIM_BITS'(1)}};

    typedef logic [DIM_BITS-1:0]            coord_t;
    typedef coord_t [NDIM-1:0]              coords_t;
    typedef logic [SHAPE_W-1:0]             shape_t;
    typedef logic [STRIDES_W-1:0]           strides_t;
    typedef logic [OFF_BITS-1:0]            offset_t;

    // Load enables of the two offset pipeline stages
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } pipe_en_t;

endpackage

>>> rtl/core/broadcast_offset_generator_top.sv
// Walks a 4-D destination tensor in flat order (dimension 0 fastest) and
// returns, per input beat, the element offsets of the destination and of two
// broadcast sources, plus a flag on the last element. A beat with s_restart
// high returns element zero; otherwise the next element, wrapping to zero
// after the last one (the first beat after reset always returns element zero).
// Takes one beat per clock unless m_ready stalls the output; each result
// reaches m_valid through the coordinate counter register, the product
// register and the offset sum register. Extents of zero act as one.
// Configuration writes are taken at any time but must only be done while the pipeline is empty.
module broadcast_offset_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [bog_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bog_pkg::CFG_W-1:0]       cfg_wr_data,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bog_pkg::OFF_BITS-1:0]    m_dest_offset,
    output logic [bog_pkg::OFF_BITS-1:0]    m_first_offset,
    output logic [bog_pkg::OFF_BITS-1:0]    m_second_offset,
    output logic                            m_final_element
);

    bog_pkg::shape_t   dest_shape_reg, first_shape_reg, second_shape_reg;
    bog_pkg::strides_t dest_strides_reg, first_strides_reg, second_strides_reg;
    bog_pkg::coords_t  dest_c, first_c, second_c;
    bog_pkg::pipe_en_t pipe_en;
    logic valid1_reg, valid2_reg, valid3_reg;
    logic fin1, fin2_reg, fin3_reg;
    logic en1, en2, en3, accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_shape_reg     <= bog_pkg::SHAPE_RESET;
            first_shape_reg    <= bog_pkg::SHAPE_RESET;
            second_shape_reg   <= bog_pkg::SHAPE_RESET;
            dest_strides_reg   <= '0;
            first_strides_reg  <= '0;
            second_strides_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bog_pkg::REG_DEST_SHAPE:
                    dest_shape_reg <= cfg_wr_data[bog_pkg::SHAPE_W-1:0];
                bog_pkg::REG_FIRST_SHAPE:
                    first_shape_reg <= cfg_wr_data[bog_pkg::SHAPE_W-1:0];
                bog_pkg::REG_SECOND_SHAPE:
                    second_shape_reg <= cfg_wr_data[bog_pkg::SHAPE_W-1:0];
                bog_pkg::REG_DEST_STRIDES:
                    dest_strides_reg <= cfg_wr_data[bog_pkg::STRIDES_W-1:0];
                bog_pkg::REG_FIRST_STRIDES:
                    first_strides_reg <= cfg_wr_data[bog_pkg::STRIDES_W-1:0];
                bog_pkg::REG_SECOND_STRIDES:
                    second_strides_reg <= cfg_wr_data[bog_pkg::STRIDES_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when empty or when it moves on
    assign en3    = !valid3_reg || m_ready;
    assign en2    = !valid2_reg || en3;
    assign en1    = !valid1_reg || en2;
    assign s_ready = en1;
    assign accept  = s_valid && s_ready;

    assign pipe_en.prod_en = en2;
    assign pipe_en.sum_en  = en3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else begin
            if (en1) valid1_reg <= s_valid;
            if (en2) valid2_reg <= valid1_reg;
            if (en3) valid3_reg <= valid2_reg;
        end
    end

    // Last-element flag rides alongside the offsets
    always_ff @(posedge aclk) begin
        if (en2) fin2_reg <= fin1;
        if (en3) fin3_reg <= fin2_reg;
    end

    bog_coord u_coord (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load_en       (accept),
        .restart       (s_restart),
        .dest_shape    (dest_shape_reg),
        .first_shape   (first_shape_reg),
        .second_shape  (second_shape_reg),
        .dest_coords   (dest_c),
        .first_coords  (first_c),
        .second_coords (second_c),
        .final_element (fin1)
    );

    bog_offset u_dest_off (
        .aclk    (aclk),
        .en      (pipe_en),
        .coords  (dest_c),
        .strides (dest_strides_reg),
        .offset  (m_dest_offset)
    );

    bog_offset u_first_off (
        .aclk    (aclk),
        .en      (pipe_en),
        .coords  (first_c),
        .strides (first_strides_reg),
        .offset  (m_first_offset)
    );

    bog_offset u_second_off (
        .aclk    (aclk),
        .en      (pipe_en),
        .coords  (second_c),
        .strides (second_strides_reg),
        .offset  (m_second_offset)
    );

    assign m_valid         = valid3_reg;
    assign m_final_element = fin3_reg;

    // A restart beat leaves every counter at zero
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart |=>
            dest_c == '0 && first_c == '0 && second_c == '0)
        else $error("counters not cleared after restart beat");

    // Input is only held off when all three stages are full and stalled
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> valid1_reg && valid2_reg && valid3_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    // A result taken at the output always frees the input side
    a_drain_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input not ready while output drains");

endmodule

>>> rtl/core/bog_coord.sv
module bog_coord (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_en,
    input  logic              restart,
    input  bog_pkg::shape_t   dest_shape,
    input  bog_pkg::shape_t   first_shape,
    input  bog_pkg::shape_t   second_shape,
    output bog_pkg::coords_t  dest_coords,
    output bog_pkg::coords_t  first_coords,
    output bog_pkg::coords_t  second_coords,
    output logic              final_element
);

    // Zero extent behaves as one
    function automatic bog_pkg::coord_t fix_ext(input bog_pkg::coord_t e);
        fix_ext = (e == '0) ? bog_pkg::DIM_BITS'(1) : e;
    endfunction

    // Step a counter, clearing on wrap or when forced
    function automatic bog_pkg::coord_t bump(input bog_pkg::coord_t c,
                                             input bog_pkg::coord_t e,
                                             input logic clr);
        logic [bog_pkg::DIM_BITS:0] inc;
        inc = {1'b0, c} + 1'b1;
        if (clr || inc >= {1'b0, e})
            bump = '0;
        else
            bump = inc[bog_pkg::DIM_BITS-1:0];
    endfunction

    bog_pkg::coords_t dest_reg, first_reg, second_reg;
    bog_pkg::coords_t dest_next, first_next, second_next;
    bog_pkg::coords_t dest_ext, first_ext, second_ext;
    logic started_reg;
    logic fin_reg, fin_next;
    logic [bog_pkg::NDIM-1:0] wrap, fin_dim;
    logic [bog_pkg::NDIM:0] carry;
    logic clear_all;

    assign clear_all = restart || !started_reg;
    assign carry[0]  = 1'b1;

    // Per-dimension counters; a dimension steps when all lower ones wrap
    for (genvar d = 0; d < bog_pkg::NDIM; d++) begin : g_dim
        assign dest_ext[d]   = fix_ext(dest_shape[d*bog_pkg::DIM_BITS +: bog_pkg::DIM_BITS]);
        assign first_ext[d]  = fix_ext(first_shape[d*bog_pkg::DIM_BITS +: bog_pkg::DIM_BITS]);
        assign second_ext[d] = fix_ext(second_shape[d*bog_pkg::DIM_BITS +: bog_pkg::DIM_BITS]);

        assign wrap[d]      = ({1'b0, dest_reg[d]} + 1'b1) >= {1'b0, dest_ext[d]};
        assign carry[d+1]   = carry[d] && wrap[d];

        always_comb begin
            if (clear_all) begin
                dest_next[d]   = '0;
                first_next[d]  = '0;
                second_next[d] = '0;
            end else if (carry[d]) begin
                dest_next[d]   = bump(dest_reg[d], dest_ext[d], 1'b0);
                first_next[d]  = bump(first_reg[d], first_ext[d], wrap[d]);
                second_next[d] = bump(second_reg[d], second_ext[d], wrap[d]);
            end else begin
                dest_next[d]   = dest_reg[d];
                first_next[d]  = first_reg[d];
                second_next[d] = second_reg[d];
            end
        end

        assign fin_dim[d] = (dest_next[d] == dest_ext[d] - 1'b1);
    end

    assign fin_next = &fin_dim;

    // Coordinate state, updated once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_reg    <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            started_reg <= 1'b0;
            fin_reg     <= 1'b0;
        end else if (load_en) begin
            dest_reg    <= dest_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            started_reg <= 1'b1;
            fin_reg     <= fin_next;
        end
    end

    assign dest_coords   = dest_reg;
    assign first_coords  = first_reg;
    assign second_coords = second_reg;
    assign final_element = fin_reg;

endmodule

>>> rtl/core/bog_offset.sv
module bog_offset (
    input  logic               aclk,
    input  bog_pkg::pipe_en_t  en,
    input  bog_pkg::coords_t   coords,
    input  bog_pkg::strides_t  strides,
    output bog_pkg::offset_t   offset
);

    logic [bog_pkg::DIM_BITS-1:0]  c0_reg;
    logic [bog_pkg::PROD_BITS-1:0] prod_reg  [1:bog_pkg::NDIM-1];
    logic [bog_pkg::PROD_BITS-1:0] prod_next [1:bog_pkg::NDIM-1];
    bog_pkg::offset_t offset_reg, offset_next;

    // One multiplier per outer dimension
    for (genvar d = 1; d < bog_pkg::NDIM; d++) begin : g_mul
        assign prod_next[d] = bog_pkg::PROD_BITS'(coords[d]) *
            bog_pkg::PROD_BITS'(strides[(d-1)*bog_pkg::STRIDE_BITS +: bog_pkg::STRIDE_BITS]);
    end

    // Adder tree over the registered products, wraps at offset width
    always_comb begin
        offset_next = bog_pkg::OFF_BITS'(c0_reg);
        for (int d = 1; d < bog_pkg::NDIM; d++)
            offset_next = offset_next + bog_pkg::OFF_BITS'(prod_reg[d]);
    end

    always_ff @(posedge aclk) begin
        if (en.prod_en) begin
            c0_reg   <= coords[0];
            prod_reg <= prod_next;
        end
        if (en.sum_en) begin
            offset_reg <= offset_next;
        end
    end

    assign offset = offset_reg;

endmodule
